FILE: rtl/sdrx_pkg.sv
// Shared types, constants and the byte-wide CRC16 step for the SD SPI block receiver.
// No dependencies; imported by every module under rtl/.
package sdrx_pkg;

    localparam int MAX_BLOCK_BYTES_DEF = 512;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 10;
    localparam int INDEX_W     = 9;
    localparam int HUNT_W      = 17;
    localparam int CRC_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [BYTE_W-1:0] START_TOKEN_RST  = 8'hFE;
    localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = 10'd512;
    localparam logic [HUNT_W-1:0] TIMEOUT_RST      = 17'd65536;
    localparam logic [BYTE_W-1:0] BUSY_BYTE        = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_POLY         = 16'h1021;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_TOKEN  = 2'd0,
        REG_BLOCK_LENGTH = 2'd1,
        REG_TIMEOUT      = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_DATA   = 2'd1,
        PH_CRC_HI = 2'd2,
        PH_CRC_LO = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_RANGE    = 3'd2,
        ST_ECC      = 3'd3,
        ST_CTRL     = 3'd4,
        ST_DATA_ERR = 3'd5,
        ST_OTHER    = 3'd6,
        ST_BAD_CRC  = 3'd7
    } status_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
        status_t            status;
        logic               last;
    } sdrx_result_t;

    // CRC16-CCITT, MSB first, one byte per call
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/sdrx_in_stage.sv
// Input register for received bytes.
// Depends on sdrx_pkg.
module sdrx_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sdrx_pkg::BYTE_W-1:0] rx_byte,
    input  logic                      take,
    output logic                      byte_valid,
    output logic [sdrx_pkg::BYTE_W-1:0] byte_q
);
    import sdrx_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_q     = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
    end

endmodule

FILE: rtl/sdrx_core.sv
// Token hunt, data phase and CRC check state machine with the configuration registers.
// Depends on sdrx_pkg.
module sdrx_core #(
    parameter int MaxBlockBytes = sdrx_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sdrx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdrx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            step,
    input  logic [sdrx_pkg::BYTE_W-1:0]     b,
    output logic                            res_valid,
    output sdrx_pkg::sdrx_result_t          res
);
    import sdrx_pkg::*;

    logic [BYTE_W-1:0] start_token_reg;
    logic [LEN_W-1:0]  block_length_reg;
    logic [HUNT_W-1:0] timeout_reg;

    phase_t            phase_reg, phase_next;
    logic [HUNT_W-1:0] hunt_count_reg, hunt_count_next;
    logic [LEN_W-1:0]  data_count_reg, data_count_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] crc_high_reg, crc_high_next;

    logic [HUNT_W-1:0] hunt_inc;
    logic [HUNT_W-1:0] limit;
    logic [LEN_W-1:0]  data_inc;
    logic [LEN_W-1:0]  eff_len;
    logic [CRC_W-1:0]  crc_upd;
    logic              is_start, is_busy, timed_out, data_done, crc_match;
    logic              status_out;

    always_comb
    begin
        if (block_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (32'(block_length_reg) > MaxBlockBytes)
            eff_len = LEN_W'(MaxBlockBytes);
        else
            eff_len = block_length_reg;
    end

    assign limit     = (timeout_reg == '0) ? HUNT_W'(1) : timeout_reg;
    assign hunt_inc  = hunt_count_reg + HUNT_W'(1);
    assign data_inc  = data_count_reg + LEN_W'(1);
    assign crc_upd   = crc_byte(crc_reg, b);
    assign is_start  = (b == start_token_reg);
    assign is_busy   = (b == BUSY_BYTE);
    assign timed_out = (hunt_inc >= limit);
    // count wrap also closes the data phase
    assign data_done = (data_inc >= eff_len) || (data_inc == '0);
    assign crc_match = ({crc_high_reg, b} == crc_reg);

    // any status result sends the machine back to a clean hunt
    always_comb
    begin
        status_out = 1'b0;
        case (phase_reg)
            PH_HUNT:   status_out = !is_start && (!is_busy || timed_out);
            PH_CRC_LO: status_out = 1'b1;
            default:   status_out = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        hunt_count_next = hunt_count_reg;
        data_count_next = data_count_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        if (step)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (is_start)
                    begin
                        phase_next      = PH_DATA;
                        data_count_next = '0;
                        crc_next        = '0;
                    end
                    else if (is_busy)
                        hunt_count_next = hunt_inc;
                end
                PH_DATA:
                begin
                    crc_next        = crc_upd;
                    data_count_next = data_inc;
                    if (data_done)
                        phase_next = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    crc_high_next = b;
                    phase_next    = PH_CRC_LO;
                end
                default: ;
            endcase
            if (status_out)
            begin
                phase_next      = PH_HUNT;
                hunt_count_next = '0;
                data_count_next = '0;
                crc_next        = '0;
                crc_high_next   = '0;
            end
        end
    end

    // result
    always_comb
    begin
        res_valid      = 1'b0;
        res.kind       = KIND_STATUS;
        res.data_byte  = '0;
        res.byte_index = '0;
        res.status     = ST_OK;
        res.last       = 1'b1;
        case (phase_reg)
            PH_HUNT:
            begin
                res_valid = step && status_out;
                if (is_busy)
                    res.status = ST_TIMEOUT;
                else if (b[3])
                    res.status = ST_RANGE;
                else if (b[2])
                    res.status = ST_ECC;
                else if (b[1])
                    res.status = ST_CTRL;
                else if (b[0])
                    res.status = ST_DATA_ERR;
                else
                    res.status = ST_OTHER;
            end
            PH_DATA:
            begin
                res_valid      = step;
                res.kind       = KIND_DATA;
                res.data_byte  = b;
                res.byte_index = data_count_reg[INDEX_W-1:0];
                res.last       = 1'b0;
            end
            PH_CRC_LO:
            begin
                res_valid  = step;
                res.status = crc_match ? ST_OK : ST_BAD_CRC;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_token_reg  <= START_TOKEN_RST;
            block_length_reg <= BLOCK_LENGTH_RST;
            timeout_reg      <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_TOKEN:  start_token_reg  <= cfg_data[BYTE_W-1:0];
                REG_BLOCK_LENGTH: block_length_reg <= cfg_data[LEN_W-1:0];
                REG_TIMEOUT:      timeout_reg      <= cfg_data[HUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            hunt_count_reg <= '0;
            data_count_reg <= '0;
            crc_reg        <= '0;
            crc_high_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hunt_count_reg <= hunt_count_next;
            data_count_reg <= data_count_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
        end
    end

    a_start_opens_block: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_HUNT && is_start |=>
            phase_reg == PH_DATA && data_count_reg == '0 && crc_reg == '0)
        else $error("start token did not open a clean data phase");

    a_status_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_STATUS |=>
            phase_reg == PH_HUNT && hunt_count_reg == '0)
        else $error("status result did not restart the hunt");

    // the high CRC byte gives no result and moves on to the low byte
    a_crc_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_CRC_HI |-> !res_valid ##1 phase_reg == PH_CRC_LO)
        else $error("crc high byte gave a result or was not followed by low byte phase");

    a_data_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_DATA |-> !res.last && res.status == ST_OK)
        else $error("data result carries status fields");

endmodule

FILE: rtl/sdrx_out_stage.sv
// Result register between the core and the downstream channel.
// Depends on sdrx_pkg.
module sdrx_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic                   res_valid,
    input  sdrx_pkg::sdrx_result_t res,
    output logic                   slot_free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sdrx_pkg::sdrx_result_t res_q
);
    import sdrx_pkg::*;

    logic         valid_reg, valid_next;
    sdrx_result_t res_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_q     = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
            res_reg <= res;
    end

endmodule

FILE: rtl/sd_spi_data_block_receiver.sv
// SD card SPI-mode data block receiver: top level.
// Depends on sdrx_pkg, sdrx_in_stage, sdrx_core and sdrx_out_stage.
//
// Takes one card byte per transfer on rx_byte and sustains one byte per clock
// while results drain: a byte is captured in the input register at its
// transfer, is decoded and folded into the byte-wide CRC16 by the core when it
// is taken from there, and its result (if any) is loaded into the output
// register at the same take, raising out_valid. While hunting, busy
// bytes (0xFF) are counted up to timeout_bytes, the start token opens a block,
// and any other byte ends the transfer with an error class. Data bytes come
// out with their index; the two CRC bytes yield one status result carried on
// the low byte. Items that make no result (start token, busy byte, CRC high
// byte) still take their turn in the core. A held result stalls the core, and in_ready
// drops once the input register is also full.
// Configuration writes are always taken (cfg_ready is high); cfg_index 0 is
// start_token, 1 block_length, 2 timeout_bytes, and other indexes are ignored.
// Registers take effect at once, so write them only with the block idle.
module sd_spi_data_block_receiver #(
    parameter int MAX_BLOCK_BYTES = sdrx_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sdrx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdrx_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sdrx_pkg::BYTE_W-1:0]      rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             result_kind,
    output logic [sdrx_pkg::BYTE_W-1:0]      data_byte,
    output logic [sdrx_pkg::INDEX_W-1:0]     byte_index,
    output logic [2:0]                       status,
    output logic                             last
);
    import sdrx_pkg::*;

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_q;
    logic              slot_free;
    logic              take;
    logic              res_valid;
    sdrx_result_t      res;
    sdrx_result_t      res_q;

    // a byte moves into the core whenever the result slot drains or is empty
    assign take      = byte_valid && slot_free;
    assign cfg_ready = 1'b1;

    sdrx_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_q     (byte_q)
    );

    sdrx_core #(
        .MaxBlockBytes (MAX_BLOCK_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (take),
        .b         (byte_q),
        .res_valid (res_valid),
        .res       (res)
    );

    sdrx_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_q     (res_q)
    );

    assign result_kind = res_q.kind;
    assign data_byte   = res_q.data_byte;
    assign byte_index  = res_q.byte_index;
    assign status      = res_q.status;
    assign last        = res_q.last;

endmodule

FILE: test/block_rx_score_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the SD SPI block receiver: byte-level predictor and result checker.
// Depends on sdrx_pkg for result, phase, status and register types.
package block_rx_score_pkg;

    import sdrx_pkg::*;

    // CRC16-CCITT, one input bit per step, MSB first
    function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic             fb;
        logic [CRC_W-1:0] c;
        c = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[CRC_W-1] ^ b[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    class block_rx_scoreboard;

        // register copies
        logic [BYTE_W-1:0]     start_tok;
        logic [LEN_W-1:0]      block_len;
        logic [HUNT_W-1:0]     busy_max;

        // receiver state after the last accepted byte
        phase_t                phase;
        logic [HUNT_W-1:0]     hunt_count;
        logic [LEN_W-1:0]      data_count;
        logic [CRC_W-1:0]      crc_acc;
        logic [BYTE_W-1:0]     crc_high;

        sdrx_result_t          due_results[$];
        int                    mismatches;

        function new();
            start_tok  = START_TOKEN_RST;
            block_len  = BLOCK_LENGTH_RST;
            busy_max   = TIMEOUT_RST;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_HUNT;
            hunt_count = '0;
            data_count = '0;
            crc_acc    = '0;
            crc_high   = '0;
        endfunction

        function int block_bytes();
            if (block_len == 0)
                return 1;
            if (int'(block_len) > MAX_BLOCK_BYTES_DEF)
                return MAX_BLOCK_BYTES_DEF;
            return int'(block_len);
        endfunction

        function int busy_limit();
            if (busy_max == 0)
                return 1;
            return int'(busy_max);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_START_TOKEN:  start_tok = val[BYTE_W-1:0];
                REG_BLOCK_LENGTH: block_len = val[LEN_W-1:0];
                REG_TIMEOUT:      busy_max  = val[HUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void finish_transfer(input status_t st);
            sdrx_result_t r;
            r.kind       = KIND_STATUS;
            r.data_byte  = '0;
            r.byte_index = '0;
            r.status     = st;
            r.last       = 1'b1;
            due_results.push_back(r);
            restart();
        endfunction

        function void accept_byte(input logic [BYTE_W-1:0] b);
            sdrx_result_t r;
            case (phase)
                PH_HUNT:
                begin
                    if (b == start_tok)
                    begin
                        phase      = PH_DATA;
                        data_count = '0;
                        crc_acc    = '0;
                    end
                    else if (b == BUSY_BYTE)
                    begin
                        hunt_count = hunt_count + 1'b1;
                        if (int'(hunt_count) >= busy_limit())
                            finish_transfer(ST_TIMEOUT);
                    end
                    else if (b[3])
                        finish_transfer(ST_RANGE);
                    else if (b[2])
                        finish_transfer(ST_ECC);
                    else if (b[1])
                        finish_transfer(ST_CTRL);
                    else if (b[0])
                        finish_transfer(ST_DATA_ERR);
                    else
                        finish_transfer(ST_OTHER);
                end
                PH_DATA:
                begin
                    r.kind       = KIND_DATA;
                    r.data_byte  = b;
                    r.byte_index = data_count[INDEX_W-1:0];
                    r.status     = ST_OK;
                    r.last       = 1'b0;
                    due_results.push_back(r);
                    crc_acc    = crc16_next(crc_acc, b);
                    data_count = data_count + 1'b1;
                    if (data_count == 0 || int'(data_count) >= block_bytes())
                        phase = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    crc_high = b;
                    phase    = PH_CRC_LO;
                end
                default:
                begin
                    if ({crc_high, b} == crc_acc)
                        finish_transfer(ST_OK);
                    else
                        finish_transfer(ST_BAD_CRC);
                end
            endcase
        endfunction

        task report(input string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(input sdrx_result_t got);
            sdrx_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d byte %0h index %0d status %0d",
                                 got.kind, got.data_byte, got.byte_index, got.status));
                return;
            end
            want = due_results.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.data_byte != want.data_byte)
                report($sformatf("data_byte %0h, want %0h", got.data_byte, want.data_byte));
            if (got.byte_index != want.byte_index)
                report($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.last != want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
        endtask

        task close();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endtask

    endclass

endpackage

FILE: test/sd_spi_data_block_receiver_test.sv
`timescale 1ns / 100ps
// Self-checking bench for sd_spi_data_block_receiver: directed and random byte streams.
// Depends on sdrx_pkg and block_rx_score_pkg (scoreboard and CRC predictor).
module sd_spi_data_block_receiver_test;

    import sdrx_pkg::*;
    import block_rx_score_pkg::*;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // two-stage pipeline plus margin, used after the last result before a register write
    localparam int SETTLE_CYCLES = 4;
    // cycles with no transfer on any channel before the run is declared hung
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 40;      // per idling mode, three modes

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_START_TOKEN;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      rx_byte   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   result_kind;
    logic [BYTE_W-1:0]      data_byte;
    logic [INDEX_W-1:0]     byte_index;
    logic [2:0]             status;
    logic                   last;

    block_rx_scoreboard sb = new();

    int           send_idle_pct = 33;   // chance per cycle that the sender holds off
    int           recv_idle_pct = 57;   // chance per cycle that out_ready is low
    int           bytes_sent    = 0;
    int           quiet_cycles  = 0;
    sdrx_result_t seen;

    sd_spi_data_block_receiver u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .status      (status),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver back-pressure: redrawn every falling edge, so stalls land on any phase.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Result monitor: every output transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.kind       = result_kind;
            seen.data_byte  = data_byte;
            seen.byte_index = byte_index;
            seen.status     = status_t'(status);
            seen.last       = last;
            sb.check_result(seen);
        end
    end

    // Watchdog: any transfer on any channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One input transfer. Entered and left at a falling edge; valid is left high so
    // back-to-back bytes keep it up, and whoever pauses next drops it.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        // predictor advances on the same edge the byte is taken
        sb.accept_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every expected result is out, then let the pipeline empty
    // (bytes with no result may still be in flight).
    task automatic hold_input();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Register write with the block drained; bits above the register width are junk.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] word;
        word = val;
        case (idx)
            REG_START_TOKEN:  word[CFG_DATA_W-1:BYTE_W] = 9'($urandom);
            REG_BLOCK_LENGTH: word[CFG_DATA_W-1:LEN_W]  = 7'($urandom);
            default: ;
        endcase
        hold_input();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, word);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Feed random bytes until the predicted receiver is back to hunting.
    task automatic resync();
        while (sb.phase != PH_HUNT)
            send_byte(8'($urandom));
    endtask

    // Well-formed block: a few busy bytes (never enough to time out), token, data, CRC.
    task automatic send_block(input bit good_crc);
        logic [CRC_W-1:0] crc;
        int               busy;
        logic [BYTE_W-1:0] d;
        busy = $urandom_range(3);
        if (sb.start_tok != BUSY_BYTE)
            while (busy > 0 && int'(sb.hunt_count) + 1 < sb.busy_limit())
            begin
                send_byte(BUSY_BYTE);
                busy--;
            end
        send_byte(sb.start_tok);
        crc = '0;
        repeat (sb.block_bytes())
        begin
            d   = 8'($urandom);
            crc = crc16_next(crc, d);
            send_byte(d);
        end
        if (!good_crc)
            crc = crc ^ 16'($urandom_range(1, 65535));
        send_byte(crc[CRC_W-1:BYTE_W]);
        send_byte(crc[BYTE_W-1:0]);
    endtask

    // Any byte other than the token or busy byte is an error token.
    task automatic error_token();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom);
        while (b == sb.start_tok || b == BUSY_BYTE)
            b = 8'($urandom);
        send_byte(b);
    endtask

    // Busy bytes up to the timeout when it is short, else only a few; an error token when the token is 0xFF.
    task automatic busy_run();
        int n;
        if (sb.start_tok == BUSY_BYTE)
            error_token();
        else
        begin
            n = sb.busy_limit() - int'(sb.hunt_count);
            if (n > 48)
                n = $urandom_range(1, 8);
            repeat (n)
                send_byte(BUSY_BYTE);
        end
    endtask

    // New random settings; lengths stay short so random blocks stay cheap.
    task automatic shuffle_registers();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            write_reg(REG_START_TOKEN, 17'(START_TOKEN_RST));
        else if (pick < 70)
            write_reg(REG_START_TOKEN, 17'(BUSY_BYTE));
        else if (pick < 80)
            write_reg(REG_START_TOKEN, 17'h0);
        else
            write_reg(REG_START_TOKEN, 17'($urandom_range(255)));

        pick = $urandom_range(99);
        if (pick < 10)
            write_reg(REG_BLOCK_LENGTH, 17'd0);
        else if (pick < 20)
            write_reg(REG_BLOCK_LENGTH, 17'd1);
        else
            write_reg(REG_BLOCK_LENGTH, 17'($urandom_range(2, 16)));

        pick = $urandom_range(99);
        if (pick < 10)
            write_reg(REG_TIMEOUT, 17'd0);
        else if (pick < 20)
            write_reg(REG_TIMEOUT, 17'd1);
        else if (pick < 70)
            write_reg(REG_TIMEOUT, 17'($urandom_range(2, 24)));
        else if (pick < 85)
            write_reg(REG_TIMEOUT, TIMEOUT_RST);
        else
            write_reg(REG_TIMEOUT, 17'($urandom_range(1, 131071)));
    endtask

    // Mostly well-formed blocks with random content; the rest error tokens,
    // timeouts, cut-short blocks and raw noise. Register changes land between
    // transfers, sometimes in the middle of a block.
    task automatic random_traffic(input int count);
        int first;
        int pick;
        first = bytes_sent;
        while (bytes_sent - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                shuffle_registers();
            else if (pick < 70)
            begin
                resync();
                send_block($urandom_range(9) != 0);
            end
            else if (pick < 78)
            begin
                resync();
                error_token();
            end
            else if (pick < 86)
            begin
                resync();
                busy_run();
            end
            else if (pick < 93)
            begin
                // block cut short; the next resync fills it with noise
                resync();
                send_byte(sb.start_tok);
                repeat ($urandom_range(sb.block_bytes() - 1))
                    send_byte(8'($urandom));
            end
            else
                send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, sender 33% idle, receiver 57% idle ----
        write_reg(REG_BLOCK_LENGTH, 17'd4);
        write_reg(REG_TIMEOUT, 17'd3);
        write_reg(REG_START_TOKEN, 17'(START_TOKEN_RST));
        write_reg(REG_UNUSED, 17'($urandom));

        // error token classes, priority from bit 3 down; high bits alone give "other"
        send_byte(8'h0F);
        send_byte(8'h04);
        send_byte(8'h02);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hF0);
        send_byte(8'h07);

        // busy bytes up to the timeout
        repeat (3)
            send_byte(BUSY_BYTE);

        send_block(1'b1);
        send_block(1'b0);

        // token of all ones: the token test wins, so 0xFF starts a block;
        // a length of zero behaves as one
        write_reg(REG_START_TOKEN, 17'(BUSY_BYTE));
        write_reg(REG_BLOCK_LENGTH, 17'd0);
        send_block(1'b1);
        send_byte(8'h00);

        // token of zero, and a timeout of zero acting as one
        write_reg(REG_START_TOKEN, 17'h0);
        write_reg(REG_TIMEOUT, 17'd0);
        send_block(1'b1);
        send_byte(BUSY_BYTE);

        // timeout lowered below the busy count already seen
        write_reg(REG_START_TOKEN, 17'(START_TOKEN_RST));
        write_reg(REG_TIMEOUT, 17'd10);
        repeat (5)
            send_byte(BUSY_BYTE);
        write_reg(REG_TIMEOUT, 17'd1);
        send_byte(BUSY_BYTE);

        // block length cut below the bytes already received: one more data byte, then CRC
        write_reg(REG_BLOCK_LENGTH, 17'd8);
        send_byte(START_TOKEN_RST);
        repeat (5)
            send_byte(8'($urandom));
        write_reg(REG_BLOCK_LENGTH, 17'd3);
        send_byte(8'($urandom));
        send_byte(sb.crc_acc[CRC_W-1:BYTE_W]);
        send_byte(sb.crc_acc[BYTE_W-1:0]);

        // full-size block: a length above the maximum saturates to it
        write_reg(REG_TIMEOUT, 17'd1);
        write_reg(REG_BLOCK_LENGTH, 17'h3FF);
        send_block(1'b1);
        write_reg(REG_BLOCK_LENGTH, 17'd1);

        // ---- random part in three idling modes ----
        random_traffic(RANDOM_ITEMS);
        send_idle_pct = 57;
        recv_idle_pct = 33;
        random_traffic(RANDOM_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(RANDOM_ITEMS);

        // widest timeout value: a few busy bytes stay far short of it, then a block
        write_reg(REG_START_TOKEN, 17'(START_TOKEN_RST));
        write_reg(REG_BLOCK_LENGTH, 17'd2);
        write_reg(REG_TIMEOUT, 17'h1FFFF);
        resync();
        repeat (4)
            send_byte(BUSY_BYTE);
        send_block(1'b1);

        hold_input();
        sb.close();
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
